// File: rtl/utf16_complex_script_detector_macros.svh
// Assertion macros for the UTF-16 complex-script detector.
`ifndef UTF16_COMPLEX_SCRIPT_DETECTOR_MACROS_SVH
`define UTF16_COMPLEX_SCRIPT_DETECTOR_MACROS_SVH

// Implication checked at every rising edge outside reset.
`define CSD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent is checked in the following cycle.
`define CSD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/utf16csd_pkg.sv
// Shared types, range tables and classification functions of the detector.
package utf16csd_pkg;

    localparam int UNIT_W      = 16;
    localparam int HIGH_BITS_W = 10;
    localparam int CP_W        = 21;
    localparam int RANGE_COUNT = 22;

    localparam logic [UNIT_W-1:0] HIGH_SURR_LO  = 16'hD800;
    localparam logic [UNIT_W-1:0] HIGH_SURR_HI  = 16'hDBFF;
    localparam logic [UNIT_W-1:0] TRAIL_SURR_LO = 16'hDC00;
    localparam logic [UNIT_W-1:0] TRAIL_SURR_HI = 16'hDFFF;
    localparam logic [UNIT_W-1:0] COMPLEX_MIN   = 16'h02E5;

    localparam logic [CP_W-1:0] PLANE_BASE  = 21'h10000;
    localparam logic [CP_W-1:0] RI_LO       = 21'h1F1E6;
    localparam logic [CP_W-1:0] RI_HI       = 21'h1F1FF;
    localparam logic [CP_W-1:0] MAN_WOMAN_LO = 21'h1F468;
    localparam logic [CP_W-1:0] MAN_WOMAN_HI = 21'h1F469;
    localparam logic [CP_W-1:0] VS_SUPP_LO  = 21'hE0100;
    localparam logic [CP_W-1:0] VS_SUPP_HI  = 21'hE01EF;

    localparam logic [UNIT_W-1:0] COMPLEX_LO [RANGE_COUNT] = '{
        16'h02E5, 16'h0300, 16'h0591, 16'h05BF, 16'h0600, 16'h1100, 16'h135D, 16'h1700,
        16'h1900, 16'h1980, 16'h1A00, 16'h1DC0, 16'h20D0, 16'h2CEF, 16'h302A, 16'h3099,
        16'hA67C, 16'hA6F0, 16'hA800, 16'hD7B0, 16'hFE00, 16'hFE20};
    localparam logic [UNIT_W-1:0] COMPLEX_HI [RANGE_COUNT] = '{
        16'h02E9, 16'h036F, 16'h05BD, 16'h05CF, 16'h109F, 16'h11FF, 16'h135F, 16'h18AF,
        16'h194F, 16'h19DF, 16'h1CFF, 16'h1DFF, 16'h20FF, 16'h2CF1, 16'h302F, 16'h309A,
        16'hA67D, 16'hA6F1, 16'hABFF, 16'hD7FF, 16'hFE0F, 16'hFE2F};

    typedef struct packed {
        logic is_high;
        logic is_trail;
        logic unit_cx;
        logic pair_cx;
    } unit_class_t;

    typedef struct packed {
        logic pending;
        logic found;
    } track_status_t;

    function automatic logic unit_in_ranges(input logic [UNIT_W-1:0] c);
        logic hit;
        hit = 1'b0;
        for (int k = 0; k < RANGE_COUNT; k++) begin
            if (c >= COMPLEX_LO[k] && c <= COMPLEX_HI[k]) begin
                hit = 1'b1;
            end
        end
        return hit && (c >= COMPLEX_MIN);
    endfunction

    function automatic logic pair_in_ranges(input logic [HIGH_BITS_W-1:0] hi_bits,
                                            input logic [HIGH_BITS_W-1:0] lo_bits);
        logic [CP_W-1:0] cp;
        cp = PLANE_BASE + {1'b0, hi_bits, lo_bits};
        return (cp >= RI_LO && cp <= RI_HI) ||
               (cp >= MAN_WOMAN_LO && cp <= MAN_WOMAN_HI) ||
               (cp >= VS_SUPP_LO && cp <= VS_SUPP_HI);
    endfunction

endpackage

// File: rtl/utf16csd_classify.sv
// Range classification of one code unit and of a surrogate pair.
module utf16csd_classify (
    input  logic [utf16csd_pkg::UNIT_W-1:0]      code_unit,
    input  logic [utf16csd_pkg::HIGH_BITS_W-1:0] held_high_bits,
    output utf16csd_pkg::unit_class_t            unit_class
);
    import utf16csd_pkg::*;

    always_comb begin
        unit_class.is_high  = (code_unit >= HIGH_SURR_LO) && (code_unit <= HIGH_SURR_HI);
        unit_class.is_trail = (code_unit >= TRAIL_SURR_LO) && (code_unit <= TRAIL_SURR_HI);
        unit_class.unit_cx  = unit_in_ranges(code_unit);
        unit_class.pair_cx  = pair_in_ranges(held_high_bits, code_unit[HIGH_BITS_W-1:0]);
    end

endmodule

// File: rtl/utf16csd_track.sv
// Per-string state: waiting high surrogate and sticky found flag.
module utf16csd_track (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  advance,
    input  logic                                  last_unit,
    input  logic [utf16csd_pkg::UNIT_W-1:0]       code_unit,
    input  utf16csd_pkg::unit_class_t             unit_class,
    output logic [utf16csd_pkg::HIGH_BITS_W-1:0]  held_high_bits,
    output logic                                  result_next,
    output utf16csd_pkg::track_status_t           status
);
    import utf16csd_pkg::*;

    logic                   pending_reg, pending_next;
    logic [HIGH_BITS_W-1:0] held_reg, held_next;
    logic                   found_reg, found_next;
    logic                   found_upd;

    always_comb begin
        found_upd    = found_reg;
        pending_next = pending_reg;
        held_next    = held_reg;
        if (pending_reg) begin
            if (unit_class.is_trail && unit_class.pair_cx) begin
                found_upd = 1'b1;
            end
            pending_next = 1'b0;
            held_next    = '0;
        end else if (unit_class.is_high) begin
            if (!last_unit) begin
                pending_next = 1'b1;
                held_next    = code_unit[HIGH_BITS_W-1:0];
            end
        end else if (unit_class.unit_cx) begin
            found_upd = 1'b1;
        end
        found_next = found_upd;
        if (last_unit) begin
            pending_next = 1'b0;
            held_next    = '0;
            found_next   = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= 1'b0;
            held_reg    <= '0;
            found_reg   <= 1'b0;
        end else if (advance) begin
            pending_reg <= pending_next;
            held_reg    <= held_next;
            found_reg   <= found_next;
        end
    end

    assign held_high_bits = held_reg;
    assign result_next    = found_upd;
    assign status.pending = pending_reg;
    assign status.found   = found_reg;

endmodule

// File: rtl/utf16_complex_script_detector.sv
// Top level of the UTF-16 complex-script detector.
//
// Input channel s_*: one UTF-16 code unit per item, s_last_unit marks the
// final unit of a string. Result channel m_*: one item per string, given
// for the unit flagged last, m_contains_complex = 1 when the string holds a
// character that needs complex shaping.
// Datapath: input register, range compares and state update, result
// register. An item may be accepted every cycle; a string's result appears
// on m_valid from the result register once its last unit leaves the input register.
// Units that are not last flow through even while a result waits; a last
// unit waits in the input register until the result register is free, and
// s_ready drops behind it while m_ready is low.
// Reset (aresetn low, synchronous) empties both registers and clears the
// surrogate and found state, so the next unit starts a new string.
module utf16_complex_script_detector (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [utf16csd_pkg::UNIT_W-1:0]   s_code_unit,
    input  logic                              s_last_unit,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_contains_complex
);
    import utf16csd_pkg::*;

    `include "utf16_complex_script_detector_macros.svh"

    logic              in_valid_reg, in_valid_next;
    logic [UNIT_W-1:0] in_code_reg;
    logic              in_last_reg;
    logic              out_valid_reg, out_valid_next;
    logic              out_cx_reg;
    logic              out_free;
    logic              advance;
    logic              result_next;
    logic [HIGH_BITS_W-1:0] held_high_bits;
    unit_class_t       unit_class;
    track_status_t     status;

    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && (!in_last_reg || out_free);
    assign s_ready  = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance && in_last_reg) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_code_reg <= s_code_unit;
            in_last_reg <= s_last_unit;
        end
        if (advance && in_last_reg) begin
            out_cx_reg <= result_next;
        end
    end

    utf16csd_classify u_classify (
        .code_unit      (in_code_reg),
        .held_high_bits (held_high_bits),
        .unit_class     (unit_class)
    );

    utf16csd_track u_track (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .advance        (advance),
        .last_unit      (in_last_reg),
        .code_unit      (in_code_reg),
        .unit_class     (unit_class),
        .held_high_bits (held_high_bits),
        .result_next    (result_next),
        .status         (status)
    );

    assign m_valid            = out_valid_reg;
    assign m_contains_complex = out_cx_reg;

    `CSD_ASSERT_NEXT(a_end_clears_state, aclk, aresetn, advance && in_last_reg, !status.pending && !status.found, "state not cleared after last unit")
    `CSD_ASSERT_IMPL(a_last_waits_for_slot, aclk, aresetn, in_valid_reg && in_last_reg && out_valid_reg && !m_ready, !advance, "last unit overwrote a pending result")
    `CSD_ASSERT_IMPL(a_stall_has_item, aclk, aresetn, !s_ready, in_valid_reg && in_last_reg, "input stalled without a waiting last unit")
    `CSD_ASSERT_NEXT(a_found_sticky, aclk, aresetn, status.found && !(advance && in_last_reg), status.found, "found flag dropped inside a string")

endmodule
